// ===== sv/ist_pkg.sv =====
package ist_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned ValW     = 32;
  localparam int unsigned IdxW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned CountW   = 5;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]             kind;
    logic signed [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic              was_present;
    logic [CountW-1:0] count;
    logic              is_empty;
    logic              rejected;
  } res_t;

  typedef struct packed {
    logic            done;
    logic            hit;
    logic [IdxW-1:0] hit_idx;
    logic            free;
    logic [IdxW-1:0] free_idx;
  } scan_t;

endpackage

// ===== sv/ist_ram.sv =====
module ist_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ist_scan.sv =====
module ist_scan import ist_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  logic [ValW-1:0]     value_i,
  input  logic [CAPACITY-1:0] valid_i,
  output logic                rd_en_o,
  output logic [IdxW-1:0]     rd_addr_o,
  input  logic [ValW-1:0]     rd_data_i,
  output scan_t               scan_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_LAST = 3'b100
  } scan_state_e;

  scan_state_e     state_q, state_d;
  logic [IdxW-1:0] addr_q, addr_d;
  logic            cmp_pend_q, cmp_pend_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic            free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic            done_q, done_d;
  logic            entry_valid;

  assign entry_valid = valid_i[cmp_idx_q];

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    cmp_pend_d = 1'b0;
    cmp_idx_d  = addr_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    done_d     = 1'b0;
    rd_en_o    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (go_i) begin
          state_d = S_SCAN;
          addr_d  = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      S_SCAN: begin
        rd_en_o    = 1'b1;
        cmp_pend_d = 1'b1;
        if (addr_q == LastIdx) begin
          state_d = S_LAST;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_LAST: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cmp_pend_q) begin
      if (entry_valid && (rd_data_i == value_i) && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = cmp_idx_q;
      end
      if (!entry_valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = cmp_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmp_pend_q <= 1'b0;
      done_q     <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cmp_pend_q <= cmp_pend_d;
      done_q     <= done_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
  end

  assign rd_addr_o       = addr_q;
  assign scan_o.done     = done_q;
  assign scan_o.hit      = hit_q;
  assign scan_o.hit_idx  = hit_idx_q;
  assign scan_o.free     = free_q;
  assign scan_o.free_idx = free_idx_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("Scan completion lasted more than one cycle.");

  a_go_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAST) |=> (state_q == S_IDLE) && done_q)
    else $error("Scan did not complete after its last compare.");

  a_compare_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_pend_q |-> (state_q != S_IDLE))
    else $error("Compare pending while the scan was idle.");

endmodule

// ===== sv/integer_set_table_core.sv =====
// Channel   Ports                      Transfer condition
// request   start, busy, req_i         start && !busy at a rising edge
// result    res_valid_o, res_o         res_valid_o high for one cycle
//
// An item's time from its transfer to its result strobe is set by the value
// memory's single read port, which the scan walks one entry per cycle, plus
// its registered read and the final update.
// Busy drops in the same cycle the result is shown, so the next item can
// be taken then. Reset clears the valid bits and the count at once.
// The receiver cannot stall; results are never held back.
module integer_set_table_core import ist_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  logic                busy_q, busy_d;
  req_t                req_q;
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                res_valid_q;
  res_t                res_q, res_d;
  logic                accept;
  logic                ram_we;
  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  logic [ValW-1:0]     rd_data;
  scan_t               scan;
  logic [CntW+CountW-1:0] count_ext;
  logic                rejected;

  assign accept = start && !busy_q;

  ist_ram #(
    .Width(ValW),
    .Depth(CAPACITY)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(scan.free_idx),
    .wdata_i(req_q.value),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  ist_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (accept),
    .value_i  (req_q.value),
    .valid_i  (valid_q),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .scan_o   (scan)
  );

  always_comb begin
    busy_d   = busy_q;
    valid_d  = valid_q;
    count_d  = count_q;
    ram_we   = 1'b0;
    rejected = 1'b0;

    if (accept) begin
      busy_d = 1'b1;
    end

    if (scan.done) begin
      busy_d = 1'b0;
      if (req_q.kind == KIND_ADD) begin
        if (!scan.hit) begin
          if (scan.free) begin
            ram_we                  = 1'b1;
            valid_d[scan.free_idx]  = 1'b1;
            count_d                 = count_q + 1'b1;
          end else begin
            rejected = 1'b1;
          end
        end
      end else if (req_q.kind == KIND_REMOVE) begin
        if (scan.hit) begin
          valid_d[scan.hit_idx] = 1'b0;
          count_d               = count_q - 1'b1;
        end
      end
    end

    count_ext         = {{CountW{1'b0}}, count_d};
    res_d.was_present = scan.hit;
    res_d.count       = count_ext[CountW-1:0];
    res_d.is_empty    = (count_d == '0);
    res_d.rejected    = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      valid_q     <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      res_valid_q <= scan.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (scan.done) begin
      res_q <= res_d;
    end
  end

  assign busy        = busy_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("Element count disagrees with the valid bits.");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.is_empty == (count_q == '0)))
    else $error("Empty flag disagrees with the element count.");

  a_reject_new_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.rejected) |-> !res_q.was_present && (valid_q == '1))
    else $error("Add rejected although the value was present or a slot was free.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && !res_valid_q)
    else $error("Transfer did not start a scan.");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ist_pkg::*;

  localparam logic [1:0] KindSpare  = 2'd3;
  localparam int         IdleLimit  = 2000;
  localparam int         DrainWait  = 40;
  localparam int         RandItems  = 800;
  localparam int         PoolSize   = 24;
  localparam int         ReportMax  = 10;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  integer_set_table_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] value;
    bit          known;
    res_t        res;
  } dir_row_t;

  logic        set_valid [CAPACITY];
  logic [31:0] set_value [CAPACITY];
  int          set_count;
  res_t        pending_results [$];
  dir_row_t    dir_table [$];
  logic [31:0] value_pool [PoolSize];
  int          mismatches;
  int          idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic res_t mk_res(bit was_present, int count, bit is_empty, bit rejected);
    res_t r;
    r.was_present = was_present;
    r.count       = count[CountW-1:0];
    r.is_empty    = is_empty;
    r.rejected    = rejected;
    return r;
  endfunction

  function automatic res_t set_apply(req_t r);
    res_t res;
    int   hit;
    int   slot;
    bit   rej;
    hit  = -1;
    slot = -1;
    rej  = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit < 0 && set_valid[i] && set_value[i] == r.value) hit = i;
      if (slot < 0 && !set_valid[i]) slot = i;
    end
    if (r.kind == KIND_ADD) begin
      if (hit < 0) begin
        if (slot >= 0) begin
          set_valid[slot] = 1'b1;
          set_value[slot] = r.value;
          set_count++;
        end else begin
          rej = 1'b1;
        end
      end
    end else if (r.kind == KIND_REMOVE) begin
      if (hit >= 0) begin
        set_valid[hit] = 1'b0;
        if (set_count > 0) set_count--;
      end
    end
    res = mk_res(hit >= 0, set_count, set_count == 0, rej);
    return res;
  endfunction

  task automatic add_row(logic [1:0] kind, logic [31:0] value, bit known, res_t res);
    dir_row_t row;
    row.kind  = kind;
    row.value = value;
    row.known = known;
    row.res   = res;
    dir_table.push_back(row);
  endtask

  task automatic send(logic [1:0] kind, logic [31:0] value, bit known, res_t lit);
    int   gap;
    req_t r;
    res_t predicted;
    gap     = $urandom_range(0, 7);
    r.kind  = kind;
    r.value = value;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    predicted = set_apply(r);
    pending_results.push_back(known ? lit : predicted);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return $urandom;
    return value_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  function automatic logic [1:0] pick_kind(int add_pct);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel >= 97) return KindSpare;
    if (sel < add_pct) return KIND_ADD;
    if (sel < add_pct + (97 - add_pct) * 2 / 3) return KIND_REMOVE;
    return KIND_QUERY;
  endfunction

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected transfer: was_present=%0b count=%0d is_empty=%0b rejected=%0b",
                   res_o.was_present, res_o.count, res_o.is_empty, res_o.rejected);
      end else begin
        want = pending_results.pop_front();
        if (res_o.was_present !== want.was_present || res_o.count !== want.count ||
            res_o.is_empty !== want.is_empty || res_o.rejected !== want.rejected) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("mismatch: exp %0b/%0d/%0b/%0b got %0b/%0d/%0b/%0b",
                     want.was_present, want.count, want.is_empty, want.rejected,
                     res_o.was_present, res_o.count, res_o.is_empty, res_o.rejected);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int add_pct;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    mismatches  = 0;
    idle_cycles = 0;
    set_count   = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      set_valid[i] = 1'b0;
      set_value[i] = '0;
    end
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < PoolSize; i++) value_pool[i] = $urandom;

    add_row(KIND_QUERY,  32'h0000_0000, 1, mk_res(0, 0, 1, 0));
    add_row(KIND_REMOVE, 32'h0000_0005, 1, mk_res(0, 0, 1, 0));
    add_row(KIND_ADD,    32'h8000_0000, 1, mk_res(0, 1, 0, 0));
    add_row(KIND_ADD,    32'h7FFF_FFFF, 1, mk_res(0, 2, 0, 0));
    add_row(KIND_ADD,    32'h7FFF_FFFF, 1, mk_res(1, 2, 0, 0));
    add_row(KIND_QUERY,  32'h8000_0000, 1, mk_res(1, 2, 0, 0));
    add_row(KindSpare,   32'h7FFF_FFFF, 1, mk_res(1, 2, 0, 0));
    // The first element stored is removed here, then the set is filled.
    add_row(KIND_REMOVE, 32'h8000_0000, 1, mk_res(1, 1, 0, 0));
    add_row(KIND_ADD,    32'hFFFF_FFFF, 0, '0);
    add_row(KIND_ADD,    32'h0000_0000, 0, '0);
    for (int i = 0; i < 13; i++) add_row(KIND_ADD, 32'h0000_0001 << (i * 2 + 1), 0, '0);
    add_row(KIND_ADD,    32'h1234_5678, 1, mk_res(0, 16, 0, 1));
    add_row(KIND_ADD,    32'h7FFF_FFFF, 1, mk_res(1, 16, 0, 0));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[i]) send(dir_table[i].kind, dir_table[i].value,
                                dir_table[i].known, dir_table[i].res);

    for (int n = 0; n < RandItems; n++) begin
      case ((n / 100) % 4)
        0: add_pct = 20;
        1: add_pct = 50;
        2: add_pct = 75;
        default: add_pct = 40;
      endcase
      if ($urandom_range(0, 99) < 2) value_pool[$urandom_range(4, PoolSize - 1)] = $urandom;
      send(pick_kind(add_pct), pick_value(), 0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ist_pkg.sv
sv/ist_ram.sv
sv/ist_scan.sv
sv/integer_set_table_core.sv
verif/tb_top.sv
